// ===== src/tpdt_pkg.sv =====
// Shared types and constants for the triangle pixel depth test block.
package tpdt_pkg;

	// item kinds carried on s_tuser
	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_TEST  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam int NUM_VERTS = 3;
	localparam int ONE_Q14   = 16384;
	localparam int DIV_N     = 52;   // dividend bits walked by the shared divider

	typedef logic signed [27:0] mul_op_t;
	typedef logic signed [35:0] cross_t;
	typedef logic signed [53:0] weight_t;

	// clamp a wide weight into signed 16 bits
	function automatic logic [15:0] sat16(input weight_t w);
		logic [15:0] r;
		if (w > 54'sd32767) begin
			r = 16'h7FFF;
		end else if (w < -54'sd32768) begin
			r = 16'h8000;
		end else begin
			r = w[15:0];
		end
		return r;
	endfunction

endpackage

// ===== src/triangle_pixel_depth_test_top.sv =====
// Top level of the triangle pixel depth test: sequencer, shared multiplier and divider.
//
// Usage:
//   Input beats arrive on s_tvalid/s_tready; s_tuser holds the kind (load vertex,
//   test pixel, clear pixel depth), s_tdata the vertex and pixel fields.
//   Every accepted beat yields exactly one result beat on m_tvalid/m_tready.
//   A load or clear beat goes straight from acceptance to the final step.
//   A test beat runs twelve multiply/accumulate passes on one shared 28x28
//   multiplier (six for the edge cross products, six for the depth sum) and
//   two 52-step restoring divisions on one shared divider, unless the triangle
//   is degenerate. One item is in flight at a time; s_tready is low meanwhile.
//   The result sits in an output register, so a new beat can be accepted
//   while the previous result still waits for m_tready.
//   If the receiver stalls, the finished item holds in its last step until the
//   output register frees; nothing is dropped.
//   After reset the depth store is swept to the reset clear depth, one entry a
//   cycle across all SCREEN_WIDTH*SCREEN_HEIGHT entries (4096 by default);
//   s_tready stays low during the sweep. clear_depth_we writes the clear depth
//   at any time, but only while the block is idle is the effect defined.
//   The vertex store resets to all zero.
module triangle_pixel_depth_test_top
	import tpdt_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 64,
	parameter int SCREEN_HEIGHT = 64,
	parameter int DEPTH_BITS    = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        clear_depth_we,
	input  logic [23:0] clear_depth_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// kind
	input  logic [1:0]  s_tuser,
	// vertex_slot, vertex_x, vertex_y, vertex_depth, pixel_col, pixel_row, zero pad
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// inside_res, write_enable, weight_a, weight_b, weight_c, fragment_depth,
	// out_col, out_row, zero pad
	output logic [87:0] m_tdata
);
	localparam int NPIX = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW   = $clog2(NPIX);
	localparam logic [23:0] ZMASK = (DEPTH_BITS >= 24) ? 24'hFFFFFF
		: 24'((64'd1 << DEPTH_BITS) - 64'd1);
	localparam logic [DEPTH_BITS-1:0] CLR_RST = DEPTH_BITS'(ZMASK);
	localparam logic [69:0] CMAX = 70'((65'd1 << DEPTH_BITS) - 65'd1);

	localparam logic [3:0] S_CLR    = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_MUL    = 4'd2;
	localparam logic [3:0] S_ACC    = 4'd3;
	localparam logic [3:0] S_NORM   = 4'd4;
	localparam logic [3:0] S_DIVSET = 4'd5;
	localparam logic [3:0] S_DIV    = 4'd6;
	localparam logic [3:0] S_DIVFIN = 4'd7;
	localparam logic [3:0] S_WC     = 4'd8;
	localparam logic [3:0] S_FRAG   = 4'd9;
	localparam logic [3:0] S_OUT    = 4'd10;

	logic [3:0]  state_q;
	logic [AW-1:0] clr_addr_q;
	logic [23:0] clear_q;
	logic [15:0] vx_q [NUM_VERTS];
	logic [15:0] vy_q [NUM_VERTS];
	logic [23:0] vz_q [NUM_VERTS];
	logic        m_tvalid_q;

	// item and datapath registers
	logic [1:0]  kind_q;
	logic [5:0]  col_q, row_q;
	logic [3:0]  mstep_q;
	logic signed [55:0] p_q;
	logic signed [83:0] acc_q;
	cross_t      d_q, na_q, nb_q;
	logic        nz_q, inside_q, sel_q, neg_q;
	logic [51:0] dvd_q;
	logic [35:0] rem_q, den_q;
	logic [5:0]  div_cnt_q;
	weight_t     wa_q, wb_q, wc_q;
	logic [DEPTH_BITS-1:0] frag_q;
	logic [87:0] m_tdata_q;

	// input field split
	logic [1:0]  in_slot;
	logic [15:0] in_x, in_y;
	logic [23:0] in_z;
	logic [5:0]  in_col, in_row;
	assign in_slot = s_tdata[1:0];
	assign in_x    = s_tdata[17:2];
	assign in_y    = s_tdata[33:18];
	assign in_z    = s_tdata[57:34];
	assign in_col  = s_tdata[63:58];
	assign in_row  = s_tdata[69:64];

	logic accept;
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// edge differences, all in 28-bit signed operand width
	mul_op_t e1, e2, e3, e4, ef, dx, dy, px, py;
	assign e1 = mul_op_t'($signed(vy_q[1])) - mul_op_t'($signed(vy_q[2]));
	assign e2 = mul_op_t'($signed(vx_q[2])) - mul_op_t'($signed(vx_q[1]));
	assign e3 = mul_op_t'($signed(vy_q[2])) - mul_op_t'($signed(vy_q[0]));
	assign e4 = mul_op_t'($signed(vx_q[0])) - mul_op_t'($signed(vx_q[2]));
	assign ef = mul_op_t'($signed(vy_q[0])) - mul_op_t'($signed(vy_q[2]));
	assign px = $signed({18'd0, col_q, 4'd0});
	assign py = $signed({18'd0, row_q, 4'd0});
	assign dx = px - mul_op_t'($signed(vx_q[2]));
	assign dy = py - mul_op_t'($signed(vy_q[2]));

	// shared multiplier operand select; a weight splits into an unsigned low
	// half and a sign-extended high half
	mul_op_t opa, opb;
	always_comb begin
		opa = '0;
		opb = '0;
		case (mstep_q)
			4'd0: begin opa = e1; opb = e4; end
			4'd1: begin opa = e2; opb = ef; end
			4'd2: begin opa = e1; opb = dx; end
			4'd3: begin opa = e2; opb = dy; end
			4'd4: begin opa = e3; opb = dx; end
			4'd5: begin opa = e4; opb = dy; end
			4'd6: begin opa = $signed({4'd0, vz_q[0]}); opb = $signed({1'b0, wa_q[26:0]}); end
			4'd7: begin opa = $signed({4'd0, vz_q[0]}); opb = mul_op_t'($signed(wa_q[53:27])); end
			4'd8: begin opa = $signed({4'd0, vz_q[1]}); opb = $signed({1'b0, wb_q[26:0]}); end
			4'd9: begin opa = $signed({4'd0, vz_q[1]}); opb = mul_op_t'($signed(wb_q[53:27])); end
			4'd10: begin opa = $signed({4'd0, vz_q[2]}); opb = $signed({1'b0, wc_q[26:0]}); end
			4'd11: begin opa = $signed({4'd0, vz_q[2]}); opb = mul_op_t'($signed(wc_q[53:27])); end
			default: begin opa = '0; opb = '0; end
		endcase
	end

	// accumulate: clear on the first product of a sum, shift high halves up
	logic acc_first, acc_hi;
	logic signed [83:0] p_ext, acc_nxt;
	assign acc_first = (mstep_q == 4'd0) || (mstep_q == 4'd2) || (mstep_q == 4'd4)
		|| (mstep_q == 4'd6);
	assign acc_hi = (mstep_q == 4'd7) || (mstep_q == 4'd9) || (mstep_q == 4'd11);
	assign p_ext   = {{28{p_q[55]}}, p_q};
	assign acc_nxt = (acc_first ? 84'sd0 : acc_q) + (acc_hi ? (p_ext <<< 27) : p_ext);

	// sign normalization so the divisor is positive
	cross_t dn, nan, nbn;
	assign dn  = d_q[35] ? -d_q : d_q;
	assign nan = d_q[35] ? -na_q : na_q;
	assign nbn = d_q[35] ? -nb_q : nb_q;

	// divider setup: num = n*32768 + d, den = 2d
	cross_t nsel;
	logic signed [51:0] num;
	assign nsel = sel_q ? nb_q : na_q;
	assign num  = ($signed({{16{nsel[35]}}, nsel}) <<< 15) + $signed({{16{d_q[35]}}, d_q});

	// one restoring step
	logic [36:0] trial;
	logic        qbit;
	assign trial = {rem_q, dvd_q[51]};
	assign qbit  = (trial >= {1'b0, den_q});

	// floor correction for a negative dividend
	weight_t qx, wdiv;
	assign qx   = {2'b00, dvd_q};
	assign wdiv = neg_q ? (-qx - weight_t'(rem_q != '0)) : qx;

	// depth rounding and clamp; the depth sum is taken as a 64-bit
	// two's complement value
	logic [64:0] s_round;
	logic [69:0] t_round;
	logic [DEPTH_BITS-1:0] frag_nxt;
	assign s_round = {1'b0, acc_q[63:0]} + 65'd8192;
	assign t_round = 70'(s_round >> 14);
	always_comb begin
		if (acc_q[63]) begin
			frag_nxt = '0;
		end else if (t_round > CMAX) begin
			frag_nxt = DEPTH_BITS'(CMAX);
		end else begin
			frag_nxt = DEPTH_BITS'(t_round);
		end
	end

	// depth store
	logic onscreen;
	logic [AW-1:0] pix_addr;
	logic [DEPTH_BITS-1:0] z_old;
	logic out_free, out_fire, is_test, pass, mem_we;
	logic [AW-1:0] mem_waddr;
	logic [DEPTH_BITS-1:0] mem_wdata;

	assign onscreen = (13'(col_q) < 13'(SCREEN_WIDTH)) && (13'(row_q) < 13'(SCREEN_HEIGHT));
	assign pix_addr = AW'(32'(row_q) * SCREEN_WIDTH + 32'(col_q));
	assign out_free = !m_tvalid_q || m_tready;
	assign out_fire = (state_q == S_OUT) && out_free;
	assign is_test  = (kind_q == KIND_TEST) && nz_q;
	assign pass     = is_test && inside_q && onscreen && (frag_q < z_old);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pix_addr;
		mem_wdata = frag_q;
		if (state_q == S_CLR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = CLR_RST;
		end else if (out_fire) begin
			if (kind_q == KIND_CLEAR) begin
				mem_we    = onscreen;
				mem_wdata = DEPTH_BITS'(clear_q);
			end else begin
				mem_we = pass;
			end
		end
	end

	tpdt_ram #(
		.WIDTH(DEPTH_BITS),
		.DEPTH(NPIX)
	) u_depth_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (pix_addr),
		.rdata (z_old)
	);

	// result word; only a test against a non-degenerate triangle fills the
	// weight and depth fields
	logic [87:0] res_word;
	always_comb begin
		res_word = '0;
		res_word[79:74] = col_q;
		res_word[85:80] = row_q;
		if (is_test) begin
			res_word[0]     = inside_q;
			res_word[1]     = pass;
			res_word[17:2]  = sat16(wa_q);
			res_word[33:18] = sat16(wb_q);
			res_word[49:34] = sat16(wc_q);
			res_word[73:50] = 24'(frag_q);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_addr_q <= '0;
			clear_q    <= ZMASK;
			m_tvalid_q <= 1'b0;
			mstep_q    <= '0;
			div_cnt_q  <= '0;
			sel_q      <= 1'b0;
			for (int i = 0; i < NUM_VERTS; i++) begin
				vx_q[i] <= '0;
				vy_q[i] <= '0;
				vz_q[i] <= '0;
			end
		end else begin
			if (clear_depth_we) begin
				clear_q <= clear_depth_wdata & ZMASK;
			end
			// raise on a new result, drop once the receiver takes it
			if (out_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					// sweep the depth store to the far plane
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(NPIX - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (s_tuser == KIND_LOAD && in_slot < 2'(NUM_VERTS)) begin
							vx_q[in_slot] <= in_x;
							vy_q[in_slot] <= in_y;
							vz_q[in_slot] <= in_z & ZMASK;
						end
						mstep_q <= '0;
						state_q <= (s_tuser == KIND_TEST) ? S_MUL : S_OUT;
					end
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					mstep_q <= mstep_q + 4'd1;
					if (mstep_q == 4'd5) begin
						state_q <= S_NORM;
					end else if (mstep_q == 4'd11) begin
						state_q <= S_FRAG;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_NORM: begin
					sel_q   <= 1'b0;
					state_q <= nz_q ? S_DIVSET : S_OUT;
				end
				S_DIVSET: begin
					div_cnt_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 6'd1;
					if (div_cnt_q == 6'(DIV_N - 1)) begin
						state_q <= S_DIVFIN;
					end
				end
				S_DIVFIN: begin
					sel_q   <= 1'b1;
					state_q <= sel_q ? S_WC : S_DIVSET;
				end
				S_WC:   state_q <= S_MUL;
				S_FRAG: state_q <= S_OUT;
				S_OUT: begin
					// hold until the output register frees
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					kind_q <= s_tuser;
					col_q  <= in_col;
					row_q  <= in_row;
					nz_q   <= 1'b0;
				end
			end
			S_MUL: p_q <= opa * opb;
			S_ACC: begin
				acc_q <= acc_nxt;
				if (mstep_q == 4'd1) begin
					d_q <= acc_nxt[35:0];
				end
				if (mstep_q == 4'd3) begin
					na_q <= acc_nxt[35:0];
				end
				if (mstep_q == 4'd5) begin
					nb_q <= acc_nxt[35:0];
					nz_q <= (d_q != '0);
				end
			end
			S_NORM: begin
				d_q      <= dn;
				na_q     <= nan;
				nb_q     <= nbn;
				inside_q <= !nan[35] && !nbn[35] && !((dn - nan - nbn) < 0);
			end
			S_DIVSET: begin
				neg_q <= num[51];
				dvd_q <= num[51] ? 52'(-num) : 52'(num);
				rem_q <= '0;
				den_q <= {d_q[34:0], 1'b0};
			end
			S_DIV: begin
				rem_q <= qbit ? 36'(trial - {1'b0, den_q}) : trial[35:0];
				dvd_q <= {dvd_q[50:0], qbit};
			end
			S_DIVFIN: begin
				if (sel_q) begin
					wb_q <= wdiv;
				end else begin
					wa_q <= wdiv;
				end
			end
			S_WC: wc_q <= weight_t'(ONE_Q14) - wa_q - wb_q;
			S_FRAG: frag_q <= frag_nxt;
			S_OUT: begin
				if (out_free) begin
					m_tdata_q <= res_word;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// a beat is taken only when idle, then the block goes busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("accepted a beat without going busy");

	// the result register is loaded only from the final step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == S_OUT)
		else $error("result raised outside final step");

	// depth store writes only during the sweep or at result time
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_CLR || state_q == S_OUT))
		else $error("stray depth store write");

	// divider never overruns its step count
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> div_cnt_q < 6'(DIV_N))
		else $error("divider step count overrun");
endmodule

// ===== src/tpdt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tpdt_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
